[hdl/bls_pkg.sv]
// ----------------------------------------------------------------------------
// bls_pkg: shared types and constants for the bounded list with search
// Operation codes, status codes, controller states and default sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bls_pkg;

    // word width of one list entry
    localparam int DATA_W = 32;

    // default number of list entries
    localparam int DEPTH_DEFAULT = 16;

    // operation carried with each input transfer
    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_SEARCH     = 2'd3
    } op_t;

    // status returned with each result transfer
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SRCH = 2'd1,
        S_FIN  = 2'd2
    } state_t;

endpackage

[hdl/bounded_list_with_search.sv]
// ----------------------------------------------------------------------------
// bounded_list_with_search: bounded deque of 32-bit words with linear search
// Push, pop and any operation on an empty list pass from the input transfer
// through the S_FIN state into the output register. A search reads one entry
// per cycle from the store's single read port until a hit, or a miss over all
// entry_count entries. One operation is in flight at a time; the next input
// transfer can be taken in the cycle after the result is loaded, and the
// result register lets it be taken while a result waits. Reset empties the list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bounded_list_with_search #(
    parameter int DEPTH = bls_pkg::DEPTH_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // input stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [2*bls_pkg::DATA_W-1:0]          s_tdata,  // insert_value, search_key
    input  logic [1:0]                            s_tuser,  // opcode
    // result stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((2*$clog2(DEPTH+1)+7)/8)*8-1:0] m_tdata, // position, entry_total, zero pad
    output logic [1:0]                            m_tuser   // status
);
    import bls_pkg::*;

    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = IDX_W + 1;
    localparam int TDATA_W = ((2 * CNT_W + 7) / 8) * 8;

    // controller and list state
    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   head_reg;
    logic [CNT_W-1:0]   count_reg;

    // latched search key and scan state
    logic [DATA_W-1:0]  key_reg;
    logic [CNT_W-1:0]   scan_off_reg;
    logic [IDX_W-1:0]   scan_ptr_reg;
    logic               cmp_vld_reg;
    logic [CNT_W-1:0]   cmp_off_reg;

    // pending result and output register
    status_t            res_status_reg;
    logic [CNT_W-1:0]   res_pos_reg;
    logic               out_valid_reg;
    status_t            out_status_reg;
    logic [CNT_W-1:0]   out_pos_reg;
    logic [CNT_W-1:0]   out_total_reg;

    // decoded input
    op_t                in_op;
    logic [DATA_W-1:0]  in_value;
    logic [DATA_W-1:0]  in_key;
    logic               in_xfer;

    // store ports
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic               rd_en;
    logic [DATA_W-1:0]  rd_data;

    // ring arithmetic
    logic               list_full;
    logic               list_empty;
    logic [IDX_W-1:0]   head_dec;
    logic [IDX_W-1:0]   head_inc;
    logic [IDX_W-1:0]   scan_ptr_inc;
    logic [SUM_W-1:0]   tail_sum;
    logic [IDX_W-1:0]   tail_idx;

    // scan control
    logic               hit;
    logic               issue;
    logic               slot_free;
    logic               load_out;

    assign in_op    = op_t'(s_tuser);
    assign in_value = s_tdata[DATA_W-1:0];
    assign in_key   = s_tdata[2*DATA_W-1:DATA_W];
    assign in_xfer  = s_tvalid && s_tready;

    assign list_full  = (count_reg == CNT_W'(DEPTH));
    assign list_empty = (count_reg == '0);

    // ring index steps with wrap at any depth
    assign head_dec     = (head_reg == '0) ? IDX_W'(DEPTH - 1) : head_reg - 1'b1;
    assign head_inc     = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign scan_ptr_inc = (scan_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : scan_ptr_reg + 1'b1;
    assign tail_sum     = {1'b0, head_reg} + SUM_W'(count_reg);
    assign tail_idx     = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
                                                      : tail_sum[IDX_W-1:0];

    // compare the entry read last cycle, issue the next read
    assign hit       = cmp_vld_reg && (rd_data == key_reg);
    assign issue     = !hit && (scan_off_reg < count_reg);
    assign slot_free = !out_valid_reg || m_tready;

    // entry store
    bls_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_value),
        .rd_en   (rd_en),
        .rd_addr (scan_ptr_reg),
        .rd_data (rd_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if ((in_op == OP_SEARCH) && !list_empty)
                    begin
                        state_next = S_SRCH;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_SRCH:
            begin
                if (!issue)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // controller outputs
    always_comb
    begin
        s_tready = 1'b0;
        rd_en    = 1'b0;
        load_out = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = tail_idx;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (in_xfer && !list_full)
                begin
                    if (in_op == OP_PUSH_FRONT)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = head_dec;
                    end
                    else if (in_op == OP_PUSH_BACK)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = tail_idx;
                    end
                end
            end
            S_SRCH:
            begin
                rd_en = issue;
            end
            S_FIN:
            begin
                load_out = slot_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // list pointers, updated when the operation is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (in_xfer)
        begin
            unique case (in_op)
                OP_PUSH_FRONT:
                begin
                    if (!list_full)
                    begin
                        head_reg  <= head_dec;
                        count_reg <= count_reg + 1'b1;
                    end
                end
                OP_PUSH_BACK:
                begin
                    if (!list_full)
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
                OP_POP_FRONT:
                begin
                    if (!list_empty)
                    begin
                        head_reg  <= head_inc;
                        count_reg <= count_reg - 1'b1;
                    end
                end
                OP_SEARCH:
                begin
                    head_reg <= head_reg;
                end
                default:
                begin
                    head_reg <= head_reg;
                end
            endcase
        end
    end

    // scan control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_vld_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            cmp_vld_reg <= 1'b0;
        end
        else if (state_reg == S_SRCH)
        begin
            cmp_vld_reg <= issue;
        end
    end

    // scan pointers, key and pending result
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            key_reg      <= in_key;
            scan_off_reg <= '0;
            scan_ptr_reg <= head_reg;
            res_pos_reg  <= '0;
            unique case (in_op)
                OP_PUSH_FRONT, OP_PUSH_BACK:
                begin
                    res_status_reg <= list_full ? ST_FULL : ST_OK;
                end
                OP_POP_FRONT, OP_SEARCH:
                begin
                    res_status_reg <= list_empty ? ST_EMPTY : ST_OK;
                end
                default:
                begin
                    res_status_reg <= ST_OK;
                end
            endcase
        end
        else if (state_reg == S_SRCH)
        begin
            if (hit)
            begin
                res_status_reg <= ST_OK;
                res_pos_reg    <= cmp_off_reg + 1'b1;
            end
            else if (issue)
            begin
                cmp_off_reg  <= scan_off_reg;
                scan_off_reg <= scan_off_reg + 1'b1;
                scan_ptr_reg <= scan_ptr_inc;
            end
            else
            begin
                res_status_reg <= ST_NOT_FOUND;
                res_pos_reg    <= '0;
            end
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_pos_reg    <= res_pos_reg;
            out_total_reg  <= count_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = TDATA_W'({out_total_reg, out_pos_reg});

    // count never passes the list depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // a scan only runs over a non-empty list
    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRCH) |-> !list_empty)
        else $error("scan of an empty list");

    // a position is reported only with a successful search
    a_pos_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (out_status_reg != ST_OK)) |-> (out_pos_reg == '0))
        else $error("position reported with failing status");

    // a hit never points past the live entries
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRCH && hit) |=> (res_pos_reg <= count_reg))
        else $error("search position beyond entry count");

endmodule

[hdl/bls_ram.sv]
// ----------------------------------------------------------------------------
// bls_ram: entry store of the list
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bls_ram #(
    parameter int DEPTH = bls_pkg::DEPTH_DEFAULT
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [bls_pkg::DATA_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [bls_pkg::DATA_W-1:0] rd_data
);
    import bls_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
